@@ hdl/cpal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpal_pkg: shared types and constants of the cascaded attitude loop
// Field widths, fixed-point format, register codes and reset values, and the
// gain set that the top level hands to the serial PID core.
// ----------------------------------------------------------------------------
package cpal_pkg;

  // Q12.4 angles and rates, Q4.12 gains
  localparam int DATA_W = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int FRAC_W = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Defaults of the top-level parameters
  localparam int INTEGRAL_LIMIT_DEF = 160;
  localparam int ANGLE_WRAP_DEF     = 0;

  // Half and full turn in Q12.4 degrees
  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;

  // Register reset values
  localparam logic [GAIN_W-1:0] OUTER_KP_RST  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] OUTER_KI_RST  = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] OUTER_KD_RST  = GAIN_W'(0);
  localparam logic [LIM_W-1:0]  OUTER_LIM_RST = LIM_W'(3200);
  localparam logic [GAIN_W-1:0] INNER_KP_RST  = GAIN_W'(328);
  localparam logic [GAIN_W-1:0] INNER_KI_RST  = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] INNER_KD_RST  = GAIN_W'(492);
  localparam logic [LIM_W-1:0]  INNER_LIM_RST = LIM_W'(320);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER_KP  = 3'd0,
    CFG_OUTER_KI  = 3'd1,
    CFG_OUTER_KD  = 3'd2,
    CFG_OUTER_LIM = 3'd3,
    CFG_INNER_KP  = 3'd4,
    CFG_INNER_KI  = 3'd5,
    CFG_INNER_KD  = 3'd6,
    CFG_INNER_LIM = 3'd7
  } cfg_idx_e;

  // Gain set of one PID loop
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  limit;
  } pid_gains_t;

endpackage

@@ hdl/cpal_pid_serial.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpal_pid_serial: bit-serial PID term engine
// Forms P, I and D products with three serial-parallel multipliers that take
// one gain bit per cycle, then adds the shifted terms and clamps the sum to
// the output limit.
// ----------------------------------------------------------------------------
module cpal_pid_serial (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cpal_pkg::DATA_W-1:0] err_i,    // signed error
  input  logic [cpal_pkg::DATA_W-1:0] prev_i,   // signed previous error
  input  logic [cpal_pkg::DATA_W-1:0] integ_i,  // signed updated integral
  input  cpal_pkg::pid_gains_t        gains_i,
  output logic                       done_o,
  output logic [cpal_pkg::DATA_W-1:0] out_o     // signed clamped result
);
  import cpal_pkg::*;

  localparam int OP_W   = DATA_W + 1;
  localparam int ACC_W  = OP_W + 1;
  localparam int PROD_W = ACC_W + GAIN_W - FRAC_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CNT_W  = $clog2(GAIN_W);
  localparam int NTERM  = 3;
  localparam int TERM_P = 0;
  localparam int TERM_I = 1;
  localparam int TERM_D = 2;

  logic [OP_W-1:0]   op_q   [NTERM];
  logic [GAIN_W-1:0] gsh_q  [NTERM];
  logic [ACC_W-1:0]  acc_q  [NTERM];
  logic [GAIN_W-1:0] lo_q   [NTERM];
  logic [ACC_W-1:0]  acc_d  [NTERM];
  logic [GAIN_W-1:0] lo_d   [NTERM];
  logic [ACC_W-1:0]  psum   [NTERM];
  logic [OP_W-1:0]   op_start [NTERM];
  logic [LIM_W-1:0]  lim_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              fin_q;
  logic              done_q;
  logic [DATA_W-1:0] out_q;
  logic signed [SUM_W-1:0] term_sum;
  logic signed [SUM_W-1:0] lim_s;
  logic [DATA_W-1:0] out_d;

  // Widen operands; the derivative difference keeps its full 17 bits
  always_comb begin
    op_start[TERM_P] = {err_i[DATA_W-1], err_i};
    op_start[TERM_I] = {integ_i[DATA_W-1], integ_i};
    op_start[TERM_D] = {err_i[DATA_W-1], err_i} - {prev_i[DATA_W-1], prev_i};
  end

  // One multiplier step per term: add, then shift one bit into the low word
  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      psum[t]  = acc_q[t] + (gsh_q[t][0] ? {op_q[t][OP_W-1], op_q[t]} : '0);
      acc_d[t] = {psum[t][ACC_W-1], psum[t][ACC_W-1:1]};
      lo_d[t]  = {psum[t][0], lo_q[t][GAIN_W-1:1]};
    end
  end

  // Sum the products shifted right by FRAC_W and clamp to the limit
  always_comb begin
    term_sum = '0;
    for (int t = 0; t < NTERM; t++) begin
      term_sum = term_sum + SUM_W'($signed({acc_q[t], lo_q[t][GAIN_W-1:FRAC_W]}));
    end
    lim_s = $signed({{(SUM_W-LIM_W){1'b0}}, lim_q});
    if (term_sum > lim_s) begin
      out_d = DATA_W'(lim_s);
    end else if (term_sum < -lim_s) begin
      out_d = DATA_W'(-lim_s);
    end else begin
      out_d = DATA_W'(term_sum);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int t = 0; t < NTERM; t++) begin
        op_q[t]  <= op_start[t];
        acc_q[t] <= '0;
        lo_q[t]  <= '0;
      end
      gsh_q[TERM_P] <= gains_i.kp;
      gsh_q[TERM_I] <= gains_i.ki;
      gsh_q[TERM_D] <= gains_i.kd;
      lim_q         <= gains_i.limit;
    end else if (busy_q) begin
      for (int t = 0; t < NTERM; t++) begin
        acc_q[t] <= acc_d[t];
        lo_q[t]  <= lo_d[t];
        gsh_q[t] <= gsh_q[t] >> 1;
      end
    end
    if (fin_q) begin
      out_q <= out_d;
    end
  end

  // Sequence: GAIN_W shift steps, one sum cycle, then a done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      fin_q  <= 1'b0;
      done_q <= fin_q;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(GAIN_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  // A new update never starts over one in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !fin_q)
    else $error("pid core started while busy");

  // The sum cycle follows the last shift step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> fin_q && !done_q)
    else $error("pid core lost its sum cycle");

  // A delivered result lies within the captured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($signed(out_q) <= $signed({1'b0, lim_q}))
            && ($signed(out_q) >= -$signed({1'b0, lim_q})))
    else $error("pid core result outside its limit");

endmodule

@@ hdl/cascaded_pid_attitude_loop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pid_attitude_loop: one axis of an angle/rate cascaded PID
// Angle PID feeds a rate target to a rate PID; both run on one bit-serial
// PID engine, first the angle loop, then the rate loop.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (s_axis): target angle, measured angle and measured rate,
//   signed Q12.4. Output word (m_axis): drive and rate target, signed Q12.4.
//   Each accepted input word yields exactly one output word.
//   Gains and limits are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle; writes take effect on the next input word.
//   Each loop update passes through the shared engine in 16 gain-bit steps,
//   one sum and one handoff, and the block takes a new word only once the
//   last one has left the hold state.
//   s_axis_tready is high only while no word is in work. A finished result
//   waits in a hold state until the output register is free, so a stalled
//   receiver delays the next input word but never loses a result.
//   Reset loads the default gains and limits and clears both integrals and
//   previous errors; no output is valid after reset.
// ----------------------------------------------------------------------------
module cascaded_pid_attitude_loop #(
  parameter int INTEGRAL_LIMIT = cpal_pkg::INTEGRAL_LIMIT_DEF,
  parameter int ANGLE_WRAP     = cpal_pkg::ANGLE_WRAP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [cpal_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpal_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [3*cpal_pkg::DATA_W-1:0]   s_axis_tdata,  // target_angle, measured_angle,
                                                          // measured_rate
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [2*cpal_pkg::DATA_W-1:0]   m_axis_tdata   // drive, rate_target
);
  import cpal_pkg::*;

  localparam int DIFF_W = DATA_W + 2;
  localparam int INT_W  = DATA_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_OUTER = 4'b0010,
    ST_INNER = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  pid_gains_t        outer_gains_q, inner_gains_q, core_gains;
  logic [DATA_W-1:0] outer_int_q, outer_prev_q, inner_int_q, inner_prev_q;
  logic [DATA_W-1:0] rate_q, rate_tgt_q, drive_q;
  logic [2*DATA_W-1:0] m_data_q;
  logic              m_valid_q;
  logic              in_accept, out_load, core_start, core_done;
  logic [DATA_W-1:0] core_out, core_err, core_prev, core_integ;
  logic [DATA_W-1:0] tgt_in, meas_in, rate_in;
  logic [DATA_W-1:0] angle_err, rate_err, outer_int_new, inner_int_new;
  logic signed [DIFF_W-1:0] angle_diff, angle_wrapped, rate_diff;

  function automatic logic [DATA_W-1:0] sat_data(input logic signed [DIFF_W-1:0] v);
    if (v > DIFF_W'(2**(DATA_W-1) - 1)) begin
      sat_data = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -DIFF_W'(2**(DATA_W-1))) begin
      sat_data = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_data = DATA_W'(v);
    end
  endfunction

  function automatic logic [DATA_W-1:0] clamp_int(input logic [DATA_W-1:0] acc,
                                                  input logic [DATA_W-1:0] e);
    logic signed [INT_W-1:0] s;
    logic signed [INT_W-1:0] lim;
    s   = $signed({acc[DATA_W-1], acc}) + $signed({e[DATA_W-1], e});
    lim = INT_W'(INTEGRAL_LIMIT);
    if (s > lim) begin
      clamp_int = DATA_W'(lim);
    end else if (s < -lim) begin
      clamp_int = DATA_W'(-lim);
    end else begin
      clamp_int = DATA_W'(s);
    end
  endfunction

  assign tgt_in  = s_axis_tdata[DATA_W-1:0];
  assign meas_in = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign rate_in = s_axis_tdata[3*DATA_W-1:2*DATA_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_HOLD) && (!m_valid_q || m_axis_tready);

  // Angle error, optionally shifted by a full turn past a half turn, then saturated
  always_comb begin
    angle_diff = $signed({{2{tgt_in[DATA_W-1]}}, tgt_in})
               - $signed({{2{meas_in[DATA_W-1]}}, meas_in});
    angle_wrapped = angle_diff;
    if (ANGLE_WRAP != 0) begin
      if (angle_diff > DIFF_W'(HALF_TURN)) begin
        angle_wrapped = angle_diff - DIFF_W'(FULL_TURN);
      end else if (angle_diff < -DIFF_W'(HALF_TURN)) begin
        angle_wrapped = angle_diff + DIFF_W'(FULL_TURN);
      end
    end
    angle_err = sat_data(angle_wrapped);
  end

  // Rate error from the fresh rate target
  always_comb begin
    rate_diff = $signed({{2{core_out[DATA_W-1]}}, core_out})
              - $signed({{2{rate_q[DATA_W-1]}}, rate_q});
    rate_err  = sat_data(rate_diff);
  end

  assign outer_int_new = clamp_int(outer_int_q, angle_err);
  assign inner_int_new = clamp_int(inner_int_q, rate_err);

  // Steer the shared engine to the angle loop or the rate loop
  assign core_start = in_accept || ((state_q == ST_OUTER) && core_done);
  always_comb begin
    if (state_q == ST_OUTER) begin
      core_err   = rate_err;
      core_prev  = inner_prev_q;
      core_integ = inner_int_new;
      core_gains = inner_gains_q;
    end else begin
      core_err   = angle_err;
      core_prev  = outer_prev_q;
      core_integ = outer_int_new;
      core_gains = outer_gains_q;
    end
  end

  cpal_pid_serial u_pid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .err_i   (core_err),
    .prev_i  (core_prev),
    .integ_i (core_integ),
    .gains_i (core_gains),
    .done_o  (core_done),
    .out_o   (core_out)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_OUTER;
      ST_OUTER: if (core_done) state_d = ST_INNER;
      ST_INNER: if (core_done) state_d = ST_HOLD;
      ST_HOLD:  if (out_load)  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_gains_q <= '{kp: OUTER_KP_RST, ki: OUTER_KI_RST, kd: OUTER_KD_RST,
                         limit: OUTER_LIM_RST};
      inner_gains_q <= '{kp: INNER_KP_RST, ki: INNER_KI_RST, kd: INNER_KD_RST,
                         limit: INNER_LIM_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OUTER_KP:  outer_gains_q.kp    <= cfg_data_i;
        CFG_OUTER_KI:  outer_gains_q.ki    <= cfg_data_i;
        CFG_OUTER_KD:  outer_gains_q.kd    <= cfg_data_i;
        CFG_OUTER_LIM: outer_gains_q.limit <= cfg_data_i[LIM_W-1:0];
        CFG_INNER_KP:  inner_gains_q.kp    <= cfg_data_i;
        CFG_INNER_KI:  inner_gains_q.ki    <= cfg_data_i;
        CFG_INNER_KD:  inner_gains_q.kd    <= cfg_data_i;
        CFG_INNER_LIM: inner_gains_q.limit <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      outer_int_q  <= '0;
      outer_prev_q <= '0;
      inner_int_q  <= '0;
      inner_prev_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        outer_int_q  <= outer_int_new;
        outer_prev_q <= angle_err;
      end
      if ((state_q == ST_OUTER) && core_done) begin
        inner_int_q  <= inner_int_new;
        inner_prev_q <= rate_err;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rate_q <= rate_in;
    end
    if ((state_q == ST_OUTER) && core_done) begin
      rate_tgt_q <= core_out;
    end
    if ((state_q == ST_INNER) && core_done) begin
      drive_q <= core_out;
    end
    if (out_load) begin
      m_data_q <= {rate_tgt_q, drive_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Output word is only loaded from the hold state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_HOLD))
    else $error("output word loaded outside hold state");

  // The engine only finishes while a loop update is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (state_q == ST_OUTER) || (state_q == ST_INNER))
    else $error("engine finished with no update pending");

  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !m_valid_q || m_axis_tready)
    else $error("output word overwritten");

endmodule

@@ tb/cascaded_pid_attitude_loop_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pid_attitude_loop_test: self-checking bench of the attitude loop
// Drives angle/rate words into the stream input and checks every drive and
// rate target word against a cycle-free fixed-point model of both PID loops
// or, for the first rows of the short directed table sent first, against
// known results. Random words then follow under several gain/limit settings,
// with extremes among them, and three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module cascaded_pid_attitude_loop_test;
  import cpal_pkg::*;

  localparam int INTEGRAL_LIMIT_TB = INTEGRAL_LIMIT_DEF;
  localparam int ANGLE_WRAP_TB     = ANGLE_WRAP_DEF;
  localparam int NUM_DIRECTED      = 21;
  localparam int NUM_PHASES        = 9;
  localparam int WORDS_PER_PHASE   = 61;
  localparam int STALL_LIMIT       = 4000;
  localparam int DRAIN_CYCLES      = 40;
  localparam int OUTER_LOOP        = 0;
  localparam int INNER_LOOP        = 1;

  // Packed from the top down: drive sits in the low half of the word
  typedef struct packed {
    logic signed [DATA_W-1:0] rate_target;
    logic signed [DATA_W-1:0] drive;
  } loop_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_angle;
    logic signed [DATA_W-1:0] measured_angle;
    logic signed [DATA_W-1:0] measured_rate;
    logic                     fixed_result;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] rate_target;
  } stim_row_t;

  // DUT connections; the ones the bench drives are known from time zero
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [3*DATA_W-1:0]     s_axis_tdata  = '0;  // target_angle, measured_angle,
                                                 // measured_rate
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [2*DATA_W-1:0]     m_axis_tdata;        // drive, rate_target

  // Model state and registers
  logic [CFG_DATA_W-1:0]   gain_reg [8];
  longint                  loop_integral [2];
  longint                  loop_prev_error [2];
  loop_out_t               pending_outputs [$];
  stim_row_t               directed_tbl [NUM_DIRECTED];

  int                      src_idle_pct  = 0;
  int                      sink_idle_pct = 0;
  int                      mismatches    = 0;
  int                      words_sent    = 0;
  int                      words_checked = 0;
  int                      settings_used = 1;
  int                      quiet_cycles  = 0;

  cascaded_pid_attitude_loop #(
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT_TB),
    .ANGLE_WRAP     (ANGLE_WRAP_TB)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always #5ns clk_i = ~clk_i;

  // Saturate to the 16-bit signed range
  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Clamp to +/- lim
  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One PID update of the selected loop
  task automatic pid_update(input int lp, input longint e, input logic [15:0] kp,
                            input logic [15:0] ki, input logic [15:0] kd,
                            input logic [15:0] lim, output longint pid_out);
    longint p;
    longint d;
    longint i;
    p = (e * longint'(kp)) >>> FRAC_W;
    d = ((e - loop_prev_error[lp]) * longint'(kd)) >>> FRAC_W;
    loop_integral[lp] = clamp_sym(loop_integral[lp] + e, INTEGRAL_LIMIT_TB);
    i = (loop_integral[lp] * longint'(ki)) >>> FRAC_W;
    loop_prev_error[lp] = e;
    pid_out = clamp_sym(p + i + d, longint'(lim));
  endtask

  // Angle loop, then rate loop
  task automatic compute_loop_outputs(input logic signed [15:0] tgt,
                                      input logic signed [15:0] meas,
                                      input logic signed [15:0] rate,
                                      output loop_out_t res);
    longint diff;
    longint rt;
    longint dr;
    diff = longint'(tgt) - longint'(meas);
    if (ANGLE_WRAP_TB != 0) begin
      if (diff > HALF_TURN) diff -= FULL_TURN;
      else if (diff < -HALF_TURN) diff += FULL_TURN;
    end
    diff = sat16(diff);
    pid_update(OUTER_LOOP, diff, gain_reg[CFG_OUTER_KP], gain_reg[CFG_OUTER_KI],
               gain_reg[CFG_OUTER_KD], gain_reg[CFG_OUTER_LIM], rt);
    pid_update(INNER_LOOP, sat16(rt - longint'(rate)), gain_reg[CFG_INNER_KP],
               gain_reg[CFG_INNER_KI], gain_reg[CFG_INNER_KD],
               gain_reg[CFG_INNER_LIM], dr);
    res.drive       = dr[15:0];
    res.rate_target = rt[15:0];
  endtask

  // Write one register and mirror it in the model
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_OUTER_LIM || idx == CFG_INNER_LIM) gain_reg[idx] = {1'b0, val[14:0]};
    else gain_reg[idx] = val;
  endtask

  // Load a full set of gains and limits
  task automatic load_setting(input int kind);
    logic [15:0] vals [8];
    for (int k = 0; k < 8; k++) begin
      case (kind)
        0: vals[k] = (k == CFG_OUTER_LIM || k == CFG_INNER_LIM) ?
                     16'($urandom_range(0, 8000)) :
                     (k == CFG_OUTER_KI || k == CFG_INNER_KI) ?
                     16'($urandom_range(0, 2048)) :
                     16'($urandom_range(0, 16384));
        1: vals[k] = 16'hFFFF;
        2: vals[k] = 16'h0000;
        3: vals[k] = 16'($urandom_range(0, 65535));
        4: vals[k] = (k == CFG_OUTER_LIM || k == CFG_INNER_LIM) ?
                     16'($urandom_range(1000, 32767)) :
                     (k == CFG_OUTER_KI || k == CFG_INNER_KI) ?
                     16'($urandom_range(8192, 65535)) :
                     16'($urandom_range(0, 4096));
        default: vals[k] = 16'($urandom_range(0, 65535));
      endcase
    end
    // Mixed extremes: saturating outer loop into a zero inner limit
    if (kind == 5) begin
      vals[CFG_OUTER_KI]  = 16'hFFFF;
      vals[CFG_OUTER_KD]  = 16'h0000;
      vals[CFG_OUTER_LIM] = 16'h7FFF;
      vals[CFG_INNER_KP]  = 16'hFFFF;
      vals[CFG_INNER_KI]  = 16'h0000;
      vals[CFG_INNER_KD]  = 16'hFFFF;
      vals[CFG_INNER_LIM] = 16'h0000;
    end
    for (int k = 0; k < 8; k++) write_reg(cfg_idx_e'(k), vals[k]);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Offer one word, wait for the handshake, queue its expected result
  task automatic send_word(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                           input logic signed [15:0] rate, input logic fixed_result,
                           input loop_out_t fixed_res);
    loop_out_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rate, meas, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    compute_loop_outputs(tgt, meas, rate, res);
    pending_outputs.push_back(fixed_result ? fixed_res : res);
    words_sent++;
  endtask

  // Receiver: check accepted words, stall at random
  always @(posedge clk_i) begin
    loop_out_t got;
    loop_out_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      words_checked++;
      if (pending_outputs.size() == 0) begin
        $error("unexpected output word: drive %0d, rate_target %0d",
               got.drive, got.rate_target);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (got.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, got.drive);
          mismatches++;
        end
        if (got.rate_target !== want.rate_target) begin
          $error("rate_target: expected %0d, got %0d", want.rate_target, got.rate_target);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    logic signed [15:0] rate;
    loop_out_t          fixed_res;

    // Reset state of the model
    gain_reg[CFG_OUTER_KP]  = OUTER_KP_RST;
    gain_reg[CFG_OUTER_KI]  = OUTER_KI_RST;
    gain_reg[CFG_OUTER_KD]  = OUTER_KD_RST;
    gain_reg[CFG_OUTER_LIM] = {1'b0, OUTER_LIM_RST};
    gain_reg[CFG_INNER_KP]  = INNER_KP_RST;
    gain_reg[CFG_INNER_KI]  = INNER_KI_RST;
    gain_reg[CFG_INNER_KD]  = INNER_KD_RST;
    gain_reg[CFG_INNER_LIM] = {1'b0, INNER_LIM_RST};
    loop_integral   = '{0, 0};
    loop_prev_error = '{0, 0};

    // Directed words under the reset gains; first rows have known results
    directed_tbl[0]  = '{0, 0, 0, 1'b1, 0, 0};
    directed_tbl[1]  = '{32767, -32768, 0, 1'b1, 320, 3200};
    directed_tbl[2]  = '{-32768, 32767, 0, 1'b1, -320, -3200};
    directed_tbl[3]  = '{0, 0, 32767, 1'b0, 0, 0};
    directed_tbl[4]  = '{0, 0, -32768, 1'b0, 0, 0};
    directed_tbl[5]  = '{32767, 32767, 0, 1'b0, 0, 0};
    directed_tbl[6]  = '{-32768, -32768, -32768, 1'b0, 0, 0};
    directed_tbl[7]  = '{2880, 0, 0, 1'b0, 0, 0};
    directed_tbl[8]  = '{2881, 0, 0, 1'b0, 0, 0};
    directed_tbl[9]  = '{-2880, 0, 0, 1'b0, 0, 0};
    directed_tbl[10] = '{-2881, 0, 0, 1'b0, 0, 0};
    directed_tbl[11] = '{5760, 0, 100, 1'b0, 0, 0};
    directed_tbl[12] = '{0, 5761, -100, 1'b0, 0, 0};
    directed_tbl[13] = '{16, 0, 0, 1'b0, 0, 0};
    directed_tbl[14] = '{1, 0, 0, 1'b0, 0, 0};
    directed_tbl[15] = '{-1, 0, 0, 1'b0, 0, 0};
    directed_tbl[16] = '{0, 0, 1, 1'b0, 0, 0};
    directed_tbl[17] = '{200, 0, -32768, 1'b0, 0, 0};
    directed_tbl[18] = '{-200, 0, 32767, 1'b0, 0, 0};
    directed_tbl[19] = '{21845, -21846, 21845, 1'b0, 0, 0};
    directed_tbl[20] = '{-21846, 21845, -21846, 1'b0, 0, 0};

    // Hold reset, then release
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table without stalls
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      fixed_res.drive       = directed_tbl[k].drive;
      fixed_res.rate_target = directed_tbl[k].rate_target;
      send_word(directed_tbl[k].target_angle, directed_tbl[k].measured_angle,
                directed_tbl[k].measured_rate, directed_tbl[k].fixed_result, fixed_res);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);

    // Random phases: new setting each phase, stall pattern per third
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_setting(ph % 6);
      case (ph / 3)
        0: begin src_idle_pct = 34; sink_idle_pct = 77; end
        1: begin src_idle_pct = 77; sink_idle_pct = 34; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          // Any bit pattern
          0, 1: begin
            tgt  = 16'($urandom);
            meas = 16'($urandom);
            rate = 16'($urandom);
          end
          // Close to the half-turn boundary
          2: begin
            tgt  = 16'(($urandom_range(0, 1) ? 2880 : -2880)
                       + int'($urandom_range(0, 64)) - 32);
            meas = 16'(int'($urandom_range(0, 64)) - 32);
            rate = 16'(int'($urandom_range(0, 4000)) - 2000);
          end
          // Tracking: measured angle near the target
          default: begin
            tgt  = 16'(int'($urandom_range(0, 6000)) - 3000);
            meas = 16'(int'(tgt) + int'($urandom_range(0, 800)) - 400);
            rate = 16'(int'($urandom_range(0, 4000)) - 2000);
          end
        endcase
        send_word(tgt, meas, rate, 1'b0, fixed_res);
      end
      s_axis_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clk_i);
    end

    // Drain and report
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_outputs.size() != 0) begin
      $error("%0d expected output words never arrived", pending_outputs.size());
      mismatches++;
    end
    $display("Run covered %0d input words and %0d output words over %0d gain/limit settings,",
             words_sent, words_checked, settings_used);
    $display("three stall patterns on both stream sides; %0d mismatches seen", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
